// ----- design/stop_and_wait_segment_sender_top_assert.svh -----
// Assertion macros for the segment sender checker
`ifndef STOP_AND_WAIT_SEGMENT_SENDER_TOP_ASSERT_SVH
`define STOP_AND_WAIT_SEGMENT_SENDER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SWSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment sender output check failed");

// next-cycle implication
`define SWSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment sender handshake check failed");

`endif

// ----- design/swss_pkg.sv -----
// Shared types, codes and checksum helper for the segment sender
`timescale 1ns / 1ps

package swss_pkg;

    localparam int PAYLOAD_MAX_DEF = 1020;

    localparam int CNT_W  = 10;
    localparam int IDX_W  = 11;
    localparam int ALEN_W = 11;
    localparam int ATT_W  = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_FETCH   = 2'd1;
    localparam logic [1:0] ACT_ACK     = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_TX      = 3'd2;
    localparam logic [2:0] ST_ACK_OK  = 3'd3;
    localparam logic [2:0] ST_RETRY   = 3'd4;
    localparam logic [2:0] ST_FAILED  = 3'd5;
    localparam logic [2:0] ST_REFUSED = 3'd6;
    localparam logic [2:0] ST_IDLE    = 3'd7;

    localparam logic [1:0] REG_DATA_CODE    = 2'd0;
    localparam logic [1:0] REG_ACK_CODE     = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd2;
    localparam logic [1:0] REG_END_CHAR     = 2'd3;

    localparam logic [7:0]       DATA_CODE_RST    = 8'h69;
    localparam logic [7:0]       ACK_CODE_RST     = 8'h6A;
    localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 5'd16;
    localparam logic [7:0]       END_CHAR_RST     = 8'h0A;

    localparam logic [ALEN_W-1:0] ACK_LEN   = 11'd4;
    localparam logic [3:0]        SUM_OK    = 4'hF;
    localparam logic [ATT_W-1:0]  FAIL_SAT  = 5'd31;
    localparam logic [IDX_W-1:0]  HDR_BYTES = 11'd4;

    typedef struct packed {
        logic [7:0]       data_code;
        logic [7:0]       ack_code;
        logic [ATT_W-1:0] max_attempts;
        logic [7:0]       end_char;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        payload_byte;
        logic [7:0]        ack_b0;
        logic [7:0]        ack_b1;
        logic [7:0]        ack_b2;
        logic [7:0]        ack_b3;
        logic [ALEN_W-1:0] ack_length;
        logic              addr_match;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       tx_byte;
        logic             tx_last;
        logic             seq_bit;
        logic [ATT_W-1:0] attempts;
    } t_out_word;

    // fold a nibble total into a 4-bit end-around-carry sum
    function automatic logic [3:0] eac_fold(input logic [7:0] total);
        logic [4:0] x;
        x = {1'b0, total[7:4]} + {1'b0, total[3:0]};
        return x[3:0] + {3'b000, x[4]};
    endfunction

endpackage

// ----- design/swss_in_if.sv -----
// Input word channel of the segment sender
`timescale 1ns / 1ps

interface swss_in_if import swss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [7:0]        payload_byte;
    logic [7:0]        ack_b0;
    logic [7:0]        ack_b1;
    logic [7:0]        ack_b2;
    logic [7:0]        ack_b3;
    logic [ALEN_W-1:0] ack_length;
    logic              addr_match;

    modport source (
        output valid, action, payload_byte, ack_b0, ack_b1, ack_b2, ack_b3,
               ack_length, addr_match,
        input  ready
    );
    modport sink (
        input  valid, action, payload_byte, ack_b0, ack_b1, ack_b2, ack_b3,
               ack_length, addr_match,
        output ready
    );
endinterface

// ----- design/swss_out_if.sv -----
// Result word channel of the segment sender
`timescale 1ns / 1ps

interface swss_out_if import swss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [7:0]       tx_byte;
    logic             tx_last;
    logic             seq_bit;
    logic [ATT_W-1:0] attempts;

    modport source (
        output valid, status, tx_byte, tx_last, seq_bit, attempts,
        input  ready
    );
    modport sink (
        input  valid, status, tx_byte, tx_last, seq_bit, attempts,
        output ready
    );
endinterface

// ----- design/stop_and_wait_segment_sender_top.sv -----
// Top level of the stop-and-wait segment sender
//
//  channel   dir   handshake                      carries
//  i_in      in    valid/ready                    action, payload byte, ack bytes
//  o_out     out   valid/ready                    status, tx byte, last, seq, attempts
//  apb       in    psel/penable/pwrite, pready=1  four configuration registers
//
// One word per cycle sustained while o_out is ready; a result passes through the input register
// and then the result register before it is on o_out.
// Payload bytes come from a registered-read store fetched one position ahead.
// Reset is synchronous and active low; the payload store is not cleared.
// A stall on o_out holds the result register and then the input register.
`timescale 1ns / 1ps

module stop_and_wait_segment_sender_top import swss_pkg::*; #(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    swss_in_if.sink           i_in,
    swss_out_if.source        o_out
);
    t_cfg w_cfg;

    swss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    swss_core #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

// ----- design/swss_cfg_regs.sv -----
// APB configuration registers of the segment sender
`timescale 1ns / 1ps

module swss_cfg_regs import swss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_code    <= DATA_CODE_RST;
            r_cfg.ack_code     <= ACK_CODE_RST;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RST;
            r_cfg.end_char     <= END_CHAR_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_DATA_CODE:    r_cfg.data_code    <= pwdata[7:0];
                REG_ACK_CODE:     r_cfg.ack_code     <= pwdata[7:0];
                REG_MAX_ATTEMPTS: r_cfg.max_attempts <= pwdata[ATT_W-1:0];
                REG_END_CHAR:     r_cfg.end_char     <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DATA_CODE:    prdata = {24'd0, r_cfg.data_code};
            REG_ACK_CODE:     prdata = {24'd0, r_cfg.ack_code};
            REG_MAX_ATTEMPTS: prdata = {27'd0, r_cfg.max_attempts};
            REG_END_CHAR:     prdata = {24'd0, r_cfg.end_char};
        endcase
    end
endmodule

// ----- design/swss_core.sv -----
// Input register, segment state, payload store and result register
`timescale 1ns / 1ps

module swss_core import swss_pkg::*; #(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    swss_in_if.sink     i_in,
    swss_out_if.source  o_out
);
    localparam int               AW      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_MAX);

    localparam logic [1:0] PH_COLLECT = 2'd0;
    localparam logic [1:0] PH_SEND    = 2'd1;
    localparam logic [1:0] PH_WAIT    = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    logic             r_in_vld;
    t_in_word         r_in;
    logic             r_out_vld;
    t_out_word        r_out;
    logic [1:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [3:0]       r_sum,    n_sum;
    logic             r_seq,    n_seq;
    logic [IDX_W-1:0] r_fetch,  n_fetch;
    logic [ATT_W-1:0] r_fail,   n_fail;
    logic [7:0]       r_mem [PAYLOAD_MAX];
    logic [7:0]       r_rd_data;

    t_out_word        w_res;
    logic             w_adv;
    logic             w_wr;
    logic [7:0]       w_push_total;
    logic [7:0]       w_hdr_total;
    logic [7:0]       w_ack_total;
    logic [3:0]       w_hdr_sum;
    logic [7:0]       w_hdr3;
    logic             w_ack_ok;
    logic [IDX_W-1:0] w_last;
    logic [IDX_W-1:0] w_rd_idx;
    logic [ATT_W-1:0] w_fail_inc;

    assign w_adv       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || w_adv;

    assign o_out.valid    = r_out_vld;
    assign o_out.status   = r_out.status;
    assign o_out.tx_byte  = r_out.tx_byte;
    assign o_out.tx_last  = r_out.tx_last;
    assign o_out.seq_bit  = r_out.seq_bit;
    assign o_out.attempts = r_out.attempts;

    assign w_push_total = {4'd0, r_sum} + {4'd0, r_in.payload_byte[7:4]}
                        + {4'd0, r_in.payload_byte[3:0]};
    assign w_hdr_total  = {4'd0, r_sum}
                        + {4'd0, i_cfg.data_code[7:4]} + {4'd0, i_cfg.data_code[3:0]}
                        + {7'd0, r_seq}
                        + {4'd0, r_count[7:4]} + {4'd0, r_count[3:0]}
                        + {6'd0, r_count[9:8]};
    assign w_hdr_sum    = eac_fold(w_hdr_total);
    assign w_hdr3       = {~w_hdr_sum, 2'b00, r_count[9:8]};
    assign w_ack_total  = {4'd0, r_in.ack_b0[7:4]} + {4'd0, r_in.ack_b0[3:0]}
                        + {4'd0, r_in.ack_b1[7:4]} + {4'd0, r_in.ack_b1[3:0]}
                        + {4'd0, r_in.ack_b2[7:4]} + {4'd0, r_in.ack_b2[3:0]}
                        + {4'd0, r_in.ack_b3[7:4]} + {4'd0, r_in.ack_b3[3:0]};
    assign w_ack_ok     = (r_in.action == ACT_ACK) && r_in.addr_match
                        && (r_in.ack_length == ACK_LEN)
                        && (r_in.ack_b0 == i_cfg.ack_code)
                        && (r_in.ack_b1 == {7'd0, r_seq})
                        && (eac_fold(w_ack_total) == SUM_OK);
    assign w_last       = {1'b0, r_count} + IDX_W'(3);
    assign w_fail_inc   = (r_fail != FAIL_SAT) ? r_fail + ATT_W'(1) : r_fail;
    assign w_rd_idx     = n_fetch - HDR_BYTES;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_seq   = r_seq;
        n_fetch = r_fetch;
        n_fail  = r_fail;
        w_wr    = 1'b0;
        w_res.status  = ST_REFUSED;
        w_res.tx_byte = 8'd0;
        w_res.tx_last = 1'b0;
        if (w_adv) begin
            if (r_phase == PH_FAILED) begin
                w_res.status = ST_FAILED;
            end else begin
                unique case (r_in.action)
                    ACT_PUSH: begin
                        if (r_phase == PH_COLLECT && r_count < CNT_MAX) begin
                            w_wr    = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_sum   = eac_fold(w_push_total);
                            if (r_in.payload_byte == i_cfg.end_char || n_count >= CNT_MAX) begin
                                n_phase      = PH_SEND;
                                n_fetch      = '0;
                                w_res.status = ST_CLOSED;
                            end else begin
                                w_res.status = ST_TAKEN;
                            end
                        end
                    end
                    ACT_FETCH: begin
                        if (r_phase == PH_SEND) begin
                            if (r_fetch < HDR_BYTES) begin
                                unique case (r_fetch[1:0])
                                    2'd0: w_res.tx_byte = i_cfg.data_code;
                                    2'd1: w_res.tx_byte = {7'd0, r_seq};
                                    2'd2: w_res.tx_byte = r_count[7:0];
                                    2'd3: w_res.tx_byte = w_hdr3;
                                endcase
                            end else begin
                                w_res.tx_byte = r_rd_data;
                            end
                            w_res.status = ST_TX;
                            if (r_fetch >= w_last) begin
                                w_res.tx_last = 1'b1;
                                n_phase       = PH_WAIT;
                            end else begin
                                n_fetch = r_fetch + IDX_W'(1);
                            end
                        end else begin
                            w_res.status = ST_IDLE;
                        end
                    end
                    ACT_ACK, ACT_TIMEOUT: begin
                        if (r_phase == PH_SEND || r_phase == PH_WAIT) begin
                            if (w_ack_ok) begin
                                n_seq        = ~r_seq;
                                n_phase      = PH_COLLECT;
                                n_count      = '0;
                                n_sum        = '0;
                                n_fetch      = '0;
                                n_fail       = '0;
                                w_res.status = ST_ACK_OK;
                            end else begin
                                n_fail = w_fail_inc;
                                if (w_fail_inc >= i_cfg.max_attempts) begin
                                    n_phase      = PH_FAILED;
                                    w_res.status = ST_FAILED;
                                end else begin
                                    n_phase      = PH_SEND;
                                    n_fetch      = '0;
                                    w_res.status = ST_RETRY;
                                end
                            end
                        end
                    end
                endcase
            end
        end
        w_res.seq_bit  = n_seq;
        w_res.attempts = n_fail;
    end

    // prefetch the payload byte for the next fetch position
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= r_in.payload_byte;
        end
        r_rd_data <= r_mem[w_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action       <= i_in.action;
            r_in.payload_byte <= i_in.payload_byte;
            r_in.ack_b0       <= i_in.ack_b0;
            r_in.ack_b1       <= i_in.ack_b1;
            r_in.ack_b2       <= i_in.ack_b2;
            r_in.ack_b3       <= i_in.ack_b3;
            r_in.ack_length   <= i_in.ack_length;
            r_in.addr_match   <= i_in.addr_match;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_COLLECT;
            r_count   <= '0;
            r_sum     <= '0;
            r_seq     <= 1'b0;
            r_fetch   <= '0;
            r_fail    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_seq   <= n_seq;
            r_fetch <= n_fetch;
            r_fail  <= n_fail;
        end
    end
endmodule

// ----- design/swss_checker.sv -----
// Port-level checks on the segment sender result channel, bound to the top level
`timescale 1ns / 1ps
`include "stop_and_wait_segment_sender_top_assert.svh"

module swss_checker import swss_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [2:0]       i_out_status,
    input logic [7:0]       i_out_tx_byte,
    input logic             i_out_tx_last,
    input logic [ATT_W-1:0] i_out_attempts
);
    `SWSS_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `SWSS_ASSERT_IMP(a_last_is_tx, i_out_valid && i_out_tx_last, i_out_status == ST_TX)
    `SWSS_ASSERT_IMP(a_no_tx_zero, i_out_valid && i_out_status != ST_TX, i_out_tx_byte == 8'd0)
    `SWSS_ASSERT_IMP(a_ack_clears, i_out_valid && i_out_status == ST_ACK_OK, i_out_attempts == '0)
    `SWSS_ASSERT_IMP(a_retry_counts, i_out_valid && i_out_status == ST_RETRY, i_out_attempts != '0)
endmodule

bind stop_and_wait_segment_sender_top swss_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_tx_byte  (o_out.tx_byte),
    .i_out_tx_last  (o_out.tx_last),
    .i_out_attempts (o_out.attempts)
);
